// File: hdl/bpc_pkg.sv
// Package for the barometric compensation unit: calibration, queue item and
// configuration types plus fixed range constants. No dependencies.
`default_nettype none

package bpc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_PRESSURE_SENSITIVITY   = 3'd0,
    CFG_PRESSURE_OFFSET        = 3'd1,
    CFG_SENSITIVITY_TEMP_COEFF = 3'd2,
    CFG_OFFSET_TEMP_COEFF      = 3'd3,
    CFG_REFERENCE_TEMP         = 3'd4,
    CFG_TEMP_SENSITIVITY       = 3'd5
  } cfg_idx_t;

  // Calibration reset values
  localparam logic [15:0] RST_PRESSURE_SENSITIVITY   = 16'd40127;
  localparam logic [15:0] RST_PRESSURE_OFFSET        = 16'd36924;
  localparam logic [15:0] RST_SENSITIVITY_TEMP_COEFF = 16'd23317;
  localparam logic [15:0] RST_OFFSET_TEMP_COEFF      = 16'd23282;
  localparam logic [15:0] RST_REFERENCE_TEMP         = 16'd33464;
  localparam logic [15:0] RST_TEMP_SENSITIVITY       = 16'd28312;

  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sensitivity_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temp;
    logic [15:0] temp_sensitivity;
  } calib_t;

  // Temperature band of a request, decided in the front end
  typedef enum logic [1:0] {
    BAND_NORMAL   = 2'd0,  // 20.00 C or above: first order only
    BAND_LOW      = 2'd1,  // below 20.00 C: second-order correction
    BAND_VERY_LOW = 2'd2   // below -15.00 C: extra correction term
  } band_t;

  typedef struct packed {
    logic        [23:0] d1;     // raw pressure
    logic signed [24:0] dt;     // raw temperature minus reference
    logic signed [17:0] tdiff;  // first-order temperature minus 20.00 C
    band_t              band;
  } q_item_t;

  localparam int TEMP_REF       = 2000;   // 20.00 C
  localparam int TEMP_VLOW_DIFF = -3500;  // -15.00 C relative to 20.00 C
  localparam int PRESS_MIN      = 1000;
  localparam int PRESS_MAX      = 120000;
  localparam int TEMP_MIN       = -4000;
  localparam int TEMP_MAX       = 8500;

endpackage

`default_nettype wire

// File: hdl/baro_pressure_temp_compensation_unit.sv
// Top level of the barometric pressure and temperature compensation unit.
// Holds the calibration registers; instantiates bpc_front, bpc_queue, bpc_back.
//
// Usage:
//   Request channel: drive in_raw_pressure and in_raw_temperature with start
//   high; the request is taken at a rising edge where start is high and busy
//   is low. One request per cycle is sustained; busy only rises if the
//   request queue is full, which cannot happen while results drain freely.
//   Result channel: out_valid strobes for exactly one cycle with
//   out_pressure_pa (Pa), out_temperature_centi (0.01 C) and out_clamped.
//   The receiver cannot stall; results appear in request order.
//   Path from the accepting edge to the result cycle: two front stages,
//   one queue slot, six back stages. Throughput is one request per
//   cycle, set by the pipelined multipliers in front and back end.
//   Configuration: cfg_valid/cfg_ready write cfg_data to the calibration
//   word at cfg_index (0..5); other indexes are dropped. cfg_ready is
//   always high. Write only while no request is in flight.
//   Reset (rst_n low, synchronous): calibration returns to factory defaults,
//   queue and pipeline empty, no result strobes.
`default_nettype none

module baro_pressure_temp_compensation_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [23:0]        in_raw_pressure,
  input  wire logic [23:0]        in_raw_temperature,
  output logic                    out_valid,
  output logic [16:0]             out_pressure_pa,
  output logic signed [14:0]      out_temperature_centi,
  output logic                    out_clamped,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  bpc_pkg::calib_t  calib_r, calib_nxt;
  bpc_pkg::q_item_t push_item, pop_item;
  logic             push_valid, push_ready, pop_valid;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    calib_nxt = calib_r;
    if (cfg_valid && cfg_ready) begin
      case (bpc_pkg::cfg_idx_t'(cfg_index))
        bpc_pkg::CFG_PRESSURE_SENSITIVITY:   calib_nxt.pressure_sensitivity   = cfg_data;
        bpc_pkg::CFG_PRESSURE_OFFSET:        calib_nxt.pressure_offset        = cfg_data;
        bpc_pkg::CFG_SENSITIVITY_TEMP_COEFF: calib_nxt.sensitivity_temp_coeff = cfg_data;
        bpc_pkg::CFG_OFFSET_TEMP_COEFF:      calib_nxt.offset_temp_coeff      = cfg_data;
        bpc_pkg::CFG_REFERENCE_TEMP:         calib_nxt.reference_temp         = cfg_data;
        bpc_pkg::CFG_TEMP_SENSITIVITY:       calib_nxt.temp_sensitivity       = cfg_data;
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r.pressure_sensitivity   <= bpc_pkg::RST_PRESSURE_SENSITIVITY;
      calib_r.pressure_offset        <= bpc_pkg::RST_PRESSURE_OFFSET;
      calib_r.sensitivity_temp_coeff <= bpc_pkg::RST_SENSITIVITY_TEMP_COEFF;
      calib_r.offset_temp_coeff      <= bpc_pkg::RST_OFFSET_TEMP_COEFF;
      calib_r.reference_temp         <= bpc_pkg::RST_REFERENCE_TEMP;
      calib_r.temp_sensitivity       <= bpc_pkg::RST_TEMP_SENSITIVITY;
    end else begin
      calib_r <= calib_nxt;
    end
  end

  // Front end: accept, form offset and first-order temperature, classify
  bpc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .calib              (calib_r),
    .start              (start),
    .busy               (busy),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .push_valid         (push_valid),
    .push_item          (push_item),
    .push_ready         (push_ready)
  );

  // Decouple the two halves
  bpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  // Back end: compensation arithmetic and saturation
  bpc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .calib                 (calib_r),
    .pop_valid             (pop_valid),
    .pop_item              (pop_item),
    .out_valid             (out_valid),
    .out_pressure_pa       (out_pressure_pa),
    .out_temperature_centi (out_temperature_centi),
    .out_clamped           (out_clamped)
  );

endmodule

`default_nettype wire

// File: hdl/bpc_front.sv
// Front end: accepts requests, forms the temperature offset and the
// first-order temperature, and classifies the band. Uses bpc_pkg.
`default_nettype none

module bpc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bpc_pkg::calib_t  calib,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [23:0]      in_raw_pressure,
  input  wire logic [23:0]      in_raw_temperature,
  output logic                  push_valid,
  output bpc_pkg::q_item_t      push_item,
  input  wire logic             push_ready
);

  logic               f1_vld_r, f1_vld_nxt;
  logic               f2_vld_r, f2_vld_nxt;
  logic        [23:0] f1_d1_r, f2_d1_r;
  logic signed [24:0] f1_dt_r, f1_dt_nxt, f2_dt_r;
  logic signed [40:0] f2_tp_r, f2_tp_nxt;
  logic signed [17:0] tdiff;
  logic               adv;

  // Whole front advances only when the queue can take the oldest request
  assign adv  = push_ready;
  assign busy = !adv;

  assign f1_vld_nxt = start && adv;
  assign f2_vld_nxt = f1_vld_r;
  assign f1_dt_nxt  = $signed({1'b0, in_raw_temperature})
                    - $signed({1'b0, calib.reference_temp, 8'd0});
  assign f2_tp_nxt  = f1_dt_r * $signed({1'b0, calib.temp_sensitivity});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (adv) begin
      f1_vld_r <= f1_vld_nxt;
      f2_vld_r <= f2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_d1_r <= in_raw_pressure;
      f1_dt_r <= f1_dt_nxt;
      f2_d1_r <= f1_d1_r;
      f2_dt_r <= f1_dt_r;
      f2_tp_r <= f2_tp_nxt;
    end
  end

  // Floor shift by 23 is the upper slice
  assign tdiff = $signed(f2_tp_r[40:23]);

  always_comb begin
    push_item.d1    = f2_d1_r;
    push_item.dt    = f2_dt_r;
    push_item.tdiff = tdiff;
    if (tdiff < bpc_pkg::TEMP_VLOW_DIFF) begin
      push_item.band = bpc_pkg::BAND_VERY_LOW;
    end else if (tdiff < 0) begin
      push_item.band = bpc_pkg::BAND_LOW;
    end else begin
      push_item.band = bpc_pkg::BAND_NORMAL;
    end
  end

  assign push_valid = f2_vld_r;

endmodule

`default_nettype wire

// File: hdl/bpc_queue.sv
// Short request queue between front and back end. Entries are flops.
// Uses bpc_pkg for the item type.
`default_nettype none

module bpc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  input  wire bpc_pkg::q_item_t  push_item,
  output logic                   push_ready,
  output logic                   pop_valid,
  output bpc_pkg::q_item_t       pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bpc_pkg::q_item_t  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              full, do_push, do_pop;

  // Back end never stalls: pop whenever something is held
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign do_pop     = (cnt_r != '0);
  assign push_ready = !full || do_pop;
  assign do_push    = push_valid && push_ready;
  assign pop_valid  = do_pop;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bpc_back.sv
// Back end: six-stage pipeline for offset, sensitivity, second-order
// correction, pressure product and saturation. Uses bpc_pkg.
`default_nettype none

module bpc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpc_pkg::calib_t   calib,
  input  wire logic              pop_valid,
  input  wire bpc_pkg::q_item_t  pop_item,
  output logic                   out_valid,
  output logic [16:0]            out_pressure_pa,
  output logic signed [14:0]     out_temperature_centi,
  output logic                   out_clamped
);

  logic [6:1] vld_r;

  // Stage 1: products
  logic        [23:0] b1_d1_r;
  bpc_pkg::band_t     b1_band_r;
  logic signed [17:0] b1_tdiff_r;
  logic signed [40:0] b1_po_r, b1_po_nxt, b1_ps_r, b1_ps_nxt;
  logic signed [49:0] dd;
  logic        [17:0] b1_t2_r;
  logic signed [35:0] ff;
  logic signed [18:0] gb;
  logic signed [37:0] gg;
  logic        [34:0] b1_f_r, b1_g_r;

  // Stage 2: first-order terms and scaled squares
  logic        [23:0] b2_d1_r;
  bpc_pkg::band_t     b2_band_r;
  logic signed [17:0] b2_tdiff_r;
  logic        [17:0] b2_t2_r;
  logic signed [35:0] b2_off1_r, b2_off1_nxt;
  logic signed [34:0] b2_sens1_r, b2_sens1_nxt;
  logic        [37:0] b2_f5_r, b2_f5_nxt, b2_g7_r, b2_g7_nxt;
  logic        [38:0] b2_g11_r, b2_g11_nxt;

  // Stage 3: corrected offset, sensitivity, temperature
  logic               low, vlow;
  logic        [38:0] off2, sens2;
  logic        [17:0] t2c;
  logic        [23:0] b3_d1_r;
  logic signed [39:0] b3_off_r, b3_off_nxt, b3_sens_r, b3_sens_nxt;
  logic signed [19:0] b3_temp_r, b3_temp_nxt;

  // Stage 4: partial products of raw pressure times sensitivity
  logic        [43:0] b4_pp_lo_r, b4_pp_lo_nxt;
  logic signed [44:0] b4_pp_hi_r, b4_pp_hi_nxt;
  logic signed [39:0] b4_off_r;
  logic signed [19:0] b4_temp_r;

  // Stage 5: full product
  logic signed [63:0] b5_sum_r, b5_sum_nxt;
  logic signed [39:0] b5_off_r;
  logic signed [19:0] b5_temp_r;

  // Stage 6: pressure and saturation
  logic signed [43:0] q;
  logic signed [28:0] p;
  logic        [16:0] press_nxt;
  logic signed [14:0] temp_nxt;
  logic               hit_p, hit_t;
  logic        [16:0] out_press_r;
  logic signed [14:0] out_temp_r;
  logic               out_clamped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:1], pop_valid};
    end
  end

  // ---- stage 1
  assign b1_po_nxt = pop_item.dt * $signed({1'b0, calib.offset_temp_coeff});
  assign b1_ps_nxt = pop_item.dt * $signed({1'b0, calib.sensitivity_temp_coeff});
  assign dd        = pop_item.dt * pop_item.dt;
  assign ff        = pop_item.tdiff * pop_item.tdiff;
  assign gb        = 19'(pop_item.tdiff) - 19'(bpc_pkg::TEMP_VLOW_DIFF);
  assign gg        = gb * gb;

  always_ff @(posedge clk) begin
    b1_d1_r    <= pop_item.d1;
    b1_band_r  <= pop_item.band;
    b1_tdiff_r <= pop_item.tdiff;
    b1_po_r    <= b1_po_nxt;
    b1_ps_r    <= b1_ps_nxt;
    b1_t2_r    <= dd[48:31];
    b1_f_r     <= ff[34:0];
    b1_g_r     <= gg[34:0];
  end

  // ---- stage 2
  assign b2_off1_nxt  = 36'($signed({1'b0, calib.pressure_offset, 16'd0}))
                      + 36'($signed(b1_po_r[40:7]));
  assign b2_sens1_nxt = 35'($signed({1'b0, calib.pressure_sensitivity, 15'd0}))
                      + 35'($signed(b1_ps_r[40:8]));
  assign b2_f5_nxt    = 38'(b1_f_r) + 38'({b1_f_r, 2'b00});
  assign b2_g7_nxt    = 38'({b1_g_r, 3'b000}) - 38'(b1_g_r);
  assign b2_g11_nxt   = 39'({b1_g_r, 3'b000}) + 39'({b1_g_r, 1'b0}) + 39'(b1_g_r);

  always_ff @(posedge clk) begin
    b2_d1_r    <= b1_d1_r;
    b2_band_r  <= b1_band_r;
    b2_tdiff_r <= b1_tdiff_r;
    b2_t2_r    <= b1_t2_r;
    b2_off1_r  <= b2_off1_nxt;
    b2_sens1_r <= b2_sens1_nxt;
    b2_f5_r    <= b2_f5_nxt;
    b2_g7_r    <= b2_g7_nxt;
    b2_g11_r   <= b2_g11_nxt;
  end

  // ---- stage 3
  always_comb begin
    low  = 1'b0;
    vlow = 1'b0;
    case (b2_band_r)
      bpc_pkg::BAND_NORMAL: begin
      end
      bpc_pkg::BAND_LOW: begin
        low = 1'b1;
      end
      bpc_pkg::BAND_VERY_LOW: begin
        low  = 1'b1;
        vlow = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    off2  = '0;
    sens2 = '0;
    t2c   = '0;
    if (low) begin
      off2  = 39'(b2_f5_r[37:1]) + (vlow ? 39'(b2_g7_r) : 39'd0);
      sens2 = 39'(b2_f5_r[37:2]) + (vlow ? 39'(b2_g11_r[38:1]) : 39'd0);
      t2c   = b2_t2_r;
    end
  end

  assign b3_off_nxt  = 40'(b2_off1_r) - $signed({1'b0, off2});
  assign b3_sens_nxt = 40'(b2_sens1_r) - $signed({1'b0, sens2});
  assign b3_temp_nxt = 20'(b2_tdiff_r) + 20'(bpc_pkg::TEMP_REF)
                     - 20'($signed({1'b0, t2c}));

  always_ff @(posedge clk) begin
    b3_d1_r   <= b2_d1_r;
    b3_off_r  <= b3_off_nxt;
    b3_sens_r <= b3_sens_nxt;
    b3_temp_r <= b3_temp_nxt;
  end

  // ---- stage 4: split the 40-bit sensitivity into two 20-bit halves
  assign b4_pp_lo_nxt = b3_d1_r * b3_sens_r[19:0];
  assign b4_pp_hi_nxt = $signed({1'b0, b3_d1_r}) * $signed(b3_sens_r[39:20]);

  always_ff @(posedge clk) begin
    b4_pp_lo_r <= b4_pp_lo_nxt;
    b4_pp_hi_r <= b4_pp_hi_nxt;
    b4_off_r   <= b3_off_r;
    b4_temp_r  <= b3_temp_r;
  end

  // ---- stage 5: recombine; the true product fits 64 bits signed
  assign b5_sum_nxt = {b4_pp_hi_r[43:0], 20'd0} + {20'd0, b4_pp_lo_r};

  always_ff @(posedge clk) begin
    b5_sum_r  <= b5_sum_nxt;
    b5_off_r  <= b4_off_r;
    b5_temp_r <= b4_temp_r;
  end

  // ---- stage 6: floor shifts are slices, then saturate
  assign q = 44'($signed(b5_sum_r[63:21])) - 44'(b5_off_r);
  assign p = q[43:15];

  always_comb begin
    hit_p     = 1'b0;
    press_nxt = p[16:0];
    if (p < bpc_pkg::PRESS_MIN) begin
      hit_p     = 1'b1;
      press_nxt = 17'(bpc_pkg::PRESS_MIN);
    end else if (p > bpc_pkg::PRESS_MAX) begin
      hit_p     = 1'b1;
      press_nxt = 17'(bpc_pkg::PRESS_MAX);
    end
  end

  always_comb begin
    hit_t    = 1'b0;
    temp_nxt = b5_temp_r[14:0];
    if (b5_temp_r < bpc_pkg::TEMP_MIN) begin
      hit_t    = 1'b1;
      temp_nxt = 15'(bpc_pkg::TEMP_MIN);
    end else if (b5_temp_r > bpc_pkg::TEMP_MAX) begin
      hit_t    = 1'b1;
      temp_nxt = 15'(bpc_pkg::TEMP_MAX);
    end
  end

  always_ff @(posedge clk) begin
    out_press_r   <= press_nxt;
    out_temp_r    <= temp_nxt;
    out_clamped_r <= hit_p || hit_t;
  end

  assign out_valid             = vld_r[6];
  assign out_pressure_pa       = out_press_r;
  assign out_temperature_centi = out_temp_r;
  assign out_clamped           = out_clamped_r;

endmodule

`default_nettype wire
